// ===== rtl/binary_heap_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heap priority queue
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define HPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define HPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue package
// Shared types, codes and the ordering compare of the heap sequencer.
// ----------------------------------------------------------------------------
package hpq_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  // Operation codes carried on the input side.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_UP_RD,
    SQ_UP_CMP,
    SQ_POP_LAST,
    SQ_DN_RD,
    SQ_DN_CMP,
    SQ_DONE
  } seq_state_t;

  localparam int DATA_W = 32;

  // True when a belongs above b in the current ordering mode.
  function automatic logic ranks_above(input logic min_mode,
                                       input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
    logic res;
    if (min_mode) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

// ===== rtl/hpq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap entry store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_mem #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [hpq_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [hpq_pkg::DATA_W-1:0] rdata_a,
  output logic [hpq_pkg::DATA_W-1:0] rdata_b
);
  import hpq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/hpq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sequencer
// Walks one push or pop through the store, one level per read state and compare state.
// ----------------------------------------------------------------------------
module hpq_seq #(
  parameter int CAPACITY = 1024,
  parameter int CW       = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       min_mode,
  input  logic                       cmd_valid,
  input  logic                       cmd_op,
  input  logic [hpq_pkg::DATA_W-1:0] cmd_value,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_take,
  output logic [hpq_pkg::DATA_W-1:0] res_root,
  output logic [CW-1:0]              res_count,
  output hpq_pkg::status_t           res_status,
  output logic                       mem_we,
  output logic [CW-1:0]              mem_waddr,
  output logic [hpq_pkg::DATA_W-1:0] mem_wdata,
  output logic [CW-1:0]              mem_raddr_a,
  output logic [CW-1:0]              mem_raddr_b,
  input  logic [hpq_pkg::DATA_W-1:0] mem_rdata_a,
  input  logic [hpq_pkg::DATA_W-1:0] mem_rdata_b
);
  import hpq_pkg::*;

  localparam logic [CW-1:0] CAP   = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE   = CW'(1);

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] root_r;
  status_t           status_r, status_nxt;

  logic [CW:0]       left_idx;
  logic [CW:0]       right_idx;
  logic              left_ok;
  logic              right_ok;
  logic              up_above;
  logic              dn_left;
  logic [DATA_W-1:0] dn_best;
  logic              dn_right;

  // Child indexes of the hole and whether they hold entries.
  assign left_idx  = {pos_r, 1'b0};
  assign right_idx = {pos_r, 1'b1};
  assign left_ok   = (left_idx <= {1'b0, count_r});
  assign right_ok  = (right_idx <= {1'b0, count_r});

  // Shared ordering compares on the registered read data.
  assign up_above = ranks_above(min_mode, cur_r, mem_rdata_a);
  assign dn_left  = ranks_above(min_mode, mem_rdata_a, cur_r);
  assign dn_best  = dn_left ? mem_rdata_a : cur_r;
  assign dn_right = right_ok && ranks_above(min_mode, mem_rdata_b, dn_best);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: begin
        if (cmd_valid) begin
          if (cmd_op == OP_PUSH) begin
            state_nxt = (count_r == CAP) ? SQ_DONE : SQ_UP_RD;
          end else begin
            state_nxt = (count_r == '0) ? SQ_DONE : SQ_POP_LAST;
          end
        end
      end
      SQ_UP_RD: begin
        state_nxt = (pos_r == ONE) ? SQ_DONE : SQ_UP_CMP;
      end
      SQ_UP_CMP: begin
        state_nxt = up_above ? SQ_UP_RD : SQ_DONE;
      end
      SQ_POP_LAST: begin
        state_nxt = (count_r == ONE) ? SQ_DONE : SQ_DN_RD;
      end
      SQ_DN_RD: begin
        state_nxt = left_ok ? SQ_DN_CMP : SQ_DONE;
      end
      SQ_DN_CMP: begin
        state_nxt = (dn_left || dn_right) ? SQ_DN_RD : SQ_DONE;
      end
      SQ_DONE: begin
        if (res_take) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // Datapath and store control for each state.
  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = cur_r;
    mem_raddr_a = count_r;
    mem_raddr_b = count_r;
    case (state_r)
      SQ_IDLE: begin
        // The last entry is read here so a pop finds it in the next cycle.
        if (cmd_valid) begin
          status_nxt = STS_OK;
          if (cmd_op == OP_PUSH) begin
            if (count_r == CAP) begin
              status_nxt = STS_FULL;
            end else begin
              count_nxt = count_r + ONE;
              pos_nxt   = count_r + ONE;
              cur_nxt   = cmd_value;
            end
          end else if (count_r == '0) begin
            status_nxt = STS_EMPTY;
          end
        end
      end
      SQ_UP_RD: begin
        if (pos_r == ONE) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr_a = pos_r >> 1;
        end
      end
      SQ_UP_CMP: begin
        // Either the parent moves down into the hole or the value settles.
        mem_we = 1'b1;
        if (up_above) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = pos_r >> 1;
        end
      end
      SQ_POP_LAST: begin
        cur_nxt   = mem_rdata_a;
        count_nxt = count_r - ONE;
        pos_nxt   = ONE;
      end
      SQ_DN_RD: begin
        if (left_ok) begin
          mem_raddr_a = left_idx[CW-1:0];
          mem_raddr_b = right_ok ? right_idx[CW-1:0] : left_idx[CW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      SQ_DN_CMP: begin
        // The better child moves up into the hole, or the value settles.
        mem_we = 1'b1;
        if (dn_right) begin
          mem_wdata = mem_rdata_b;
          pos_nxt   = right_idx[CW-1:0];
        end else if (dn_left) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = left_idx[CW-1:0];
        end
      end
      SQ_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers, with a shadow copy of the root entry.
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
    if (mem_we && (mem_waddr == ONE)) begin
      root_r <= mem_wdata;
    end
  end

  assign idle       = (state_r == SQ_IDLE);
  assign res_valid  = (state_r == SQ_DONE);
  assign res_root   = (count_r == '0) ? '0 : root_r;
  assign res_count  = count_r;
  assign res_status = status_r;

endmodule

// ===== rtl/binary_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Push and pop of signed 32-bit values with a min or max root, one result
// beat per input beat.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  in_      in   tuser: operation (0 push, 1 pop); tdata: value
//  out_     out  tdata: root_value, entry_count, is_empty; tuser: status
//  cfg_     in   wen/wdata: min_mode (1 min at root, 0 max at root)
//
//  A push climbs from the new leaf toward the root; a pop first moves the last
//  entry to the root and then descends.
//  Each level costs one registered read of the store and one compare/write.
//  A new beat is taken once the previous one is placed in the output register.
//  Reset clears the count and sets min mode; store contents are not cleared.
//  A stalled output holds its beat while the next operation runs.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_top_macros.svh"

module binary_heap_priority_queue_top #(
  parameter  int CAPACITY = 1024,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int OUT_W    = ((hpq_pkg::DATA_W + CW + 1 + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration
  input  logic                        cfg_wen,
  input  logic                        cfg_wdata,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hpq_pkg::DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                        in_tuser,   // [0] operation
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata,  // root_value, entry_count, is_empty
  output logic [1:0]                  out_tuser   // [1:0] status
);
  import hpq_pkg::*;

  logic              min_mode_r;
  logic              in_beat;
  logic              seq_idle;
  logic              res_valid;
  logic              res_take;
  logic [DATA_W-1:0] res_root;
  logic [CW-1:0]     res_count;
  status_t           res_status;

  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [CW-1:0]     mem_raddr_a;
  logic [CW-1:0]     mem_raddr_b;
  logic [DATA_W-1:0] mem_rdata_a;
  logic [DATA_W-1:0] mem_rdata_b;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_root_r;
  logic [CW-1:0]     out_count_r;
  logic              out_empty_r;
  status_t           out_status_r;

  // Ordering mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mode_r <= 1'b1;
    end else if (cfg_wen) begin
      min_mode_r <= cfg_wdata;
    end
  end

  assign in_tready = seq_idle;
  assign in_beat   = in_tvalid && in_tready;

  hpq_seq #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .min_mode    (min_mode_r),
    .cmd_valid   (in_beat),
    .cmd_op      (in_tuser),
    .cmd_value   (in_tdata),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_root    (res_root),
    .res_count   (res_count),
    .res_status  (res_status),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  hpq_mem #(
    .DEPTH (CAPACITY + 1),
    .AW    (CW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // Output register: loaded when empty or when its beat leaves.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_root_r   <= res_root;
      out_count_r  <= res_count;
      out_empty_r  <= (res_count == '0);
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_empty_r, out_count_r, out_root_r});
  assign out_tuser  = out_status_r;

  // Checks on the sequencer and the result register.
  `HPQ_ASSERT_IMP(a_count_bound, 1'b1, res_count <= CW'(CAPACITY), "entry count above capacity")
  `HPQ_ASSERT_NXT(a_busy_after_beat, in_beat, !in_tready, "input taken while sequencer busy")
  `HPQ_ASSERT_IMP(a_empty_refusal, res_valid && (res_status == STS_EMPTY), res_count == '0, "pop refused with entries held")
  `HPQ_ASSERT_IMP(a_empty_root, out_valid_r && out_empty_r, out_root_r == '0, "nonzero root on empty heap")

endmodule
